/* design/cdd_pkg.sv */
// ----------------------------------------------------------------------------
// cdd_pkg : shared types and calendar helpers
// Date-and-time record, month lengths and the Gregorian leap test.
// ----------------------------------------------------------------------------
`default_nettype none

package cdd_pkg;

    // Broken-down date and time; field order gives the lexicographic key.
    typedef struct packed {
        logic [11:0] year;    // years since 1900
        logic [3:0]  month;   // 0 is January
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_ts;

    localparam logic [10:0] YEAR_BASE    = 11'd1900;
    localparam logic [3:0]  MONTH_JAN    = 4'd0;
    localparam logic [3:0]  MONTH_FEB    = 4'd1;
    localparam logic [3:0]  MONTH_DEC    = 4'd11;
    localparam logic [3:0]  MONTH_LIMIT  = 4'd12;
    localparam logic [7:0]  SEC_WRAP     = 8'd60;
    localparam logic [7:0]  MIN_WRAP     = 8'd60;
    localparam logic [7:0]  HOUR_WRAP    = 8'd24;
    localparam logic [7:0]  MONTH_WRAP   = 8'd12;

    // floor(y / 25) for y below 6400 is (y * RECIP_25) >> RECIP_SHIFT; the
    // quotient is kept to 8 bits.
    localparam logic [12:0] RECIP_25     = 13'd5243;
    localparam int          RECIP_SHIFT  = 17;

    // True when the full year y (up to 6399) is a Gregorian leap year.
    // Divisible by 100 means by 4 and by 25; by 400 means by 16 and by 25.
    function automatic logic is_leap(input logic [12:0] y);
        logic [25:0] prod;
        logic [7:0]  quo;
        logic [12:0] back;
        logic        by25;
        prod = 26'(y) * 26'(RECIP_25);
        quo  = prod[RECIP_SHIFT +: 8];
        back = (13'(quo) << 4) + (13'(quo) << 3) + 13'(quo);
        by25 = (back == y);
        return ((y[1:0] == 2'b00) && !by25) || ((y[3:0] == 4'b0000) && by25);
    endfunction

    // Length of 0-based month m (0..11); February follows leap.
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1:                     len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

/* design/calendar_date_difference.sv */
// ----------------------------------------------------------------------------
// calendar_date_difference : signed calendar difference of two timestamps
// Two-stage valid/ready pipeline: input register, borrow chain, result
// register.
// ----------------------------------------------------------------------------
// Usage
//   Input channel : i_valid / o_ready carry one beat holding a start and an
//                   end timestamp (year since 1900, 0-based month, day, hour,
//                   minute, second).
//   Output channel: o_valid / i_ready carry one result beat per input beat:
//                   years, months, days, hours, minutes, seconds, each two's
//                   complement, negated as a set when the start is later.
//   Path          : an accepted beat passes the input register, then the
//                   result register; o_valid rises when the result register
//                   is loaded.
//   Throughput    : a new beat enters every cycle while results are taken;
//                   the whole borrow chain plus one small constant multiply
//                   for the leap test sits between the two registers.
//   Stall         : a held result keeps its register; the input register keeps
//                   accepting until it is full and cannot drain, then o_ready
//                   drops. Nothing is lost or repeated.
//   Reset         : i_rst_n low (synchronous) empties both stages; no
//                   configuration and no stored state besides the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_difference (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [11:0]        i_start_year,
    input  wire logic [3:0]         i_start_month,
    input  wire logic [4:0]         i_start_day,
    input  wire logic [4:0]         i_start_hour,
    input  wire logic [5:0]         i_start_minute,
    input  wire logic [5:0]         i_start_second,
    input  wire logic [11:0]        i_end_year,
    input  wire logic [3:0]         i_end_month,
    input  wire logic [4:0]         i_end_day,
    input  wire logic [4:0]         i_end_hour,
    input  wire logic [5:0]         i_end_minute,
    input  wire logic [5:0]         i_end_second,
    // output channel
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [12:0]      o_diff_years,
    output logic signed [4:0]       o_diff_months,
    output logic signed [5:0]       o_diff_days,
    output logic signed [5:0]       o_diff_hours,
    output logic signed [6:0]       o_diff_minutes,
    output logic signed [6:0]       o_diff_seconds
);

    // ---------------------------------------------------------------- control
    logic r_s1_valid;
    logic r_o_valid;
    logic s1_move;   // stage 1 beat moves into the result register
    logic in_take;   // input beat accepted

    assign s1_move = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_move;
    assign in_take = i_valid && o_ready;
    assign o_valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= in_take || (r_s1_valid && !s1_move);
            r_o_valid  <= s1_move || (r_o_valid && !i_ready);
        end
    end

    // ---------------------------------------------------------- input register
    cdd_pkg::t_ts r_start;
    cdd_pkg::t_ts r_end;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_start <= '{year: i_start_year, month: i_start_month, day: i_start_day,
                         hour: i_start_hour, minute: i_start_minute,
                         second: i_start_second};
            r_end   <= '{year: i_end_year, month: i_end_month, day: i_end_day,
                         hour: i_end_hour, minute: i_end_minute,
                         second: i_end_second};
        end
    end

    // ------------------------------------------------------------ borrow chain
    logic         rev;        // start later than end: swap, negate at the end
    cdd_pkg::t_ts lo;
    cdd_pkg::t_ts hi;
    logic [7:0]   sec0, min0, hour0, day0, mon0;
    logic [7:0]   sec1, min1, hour1, day1, mon1;
    logic [13:0]  yr1;
    logic [3:0]   prev_mon;   // month before the later timestamp's month, 0..11
    logic [12:0]  full_year;
    logic [4:0]   prev_len;
    logic [7:0]   n_sec, n_min, n_hour, n_day, n_mon;
    logic [13:0]  n_yr;

    // The packed record compares field by field, most significant first.
    assign rev = (r_start > r_end);
    assign lo  = rev ? r_end   : r_start;
    assign hi  = rev ? r_start : r_end;

    // Borrow month: December before January, December for a month code
    // beyond the year. Only February needs the year, and then the later
    // timestamp's year is used as it stands.
    always_comb begin
        if (hi.month == cdd_pkg::MONTH_JAN || hi.month > cdd_pkg::MONTH_LIMIT) begin
            prev_mon = cdd_pkg::MONTH_DEC;
        end else begin
            prev_mon = hi.month - 4'd1;
        end
    end

    assign full_year = 13'(hi.year) + 13'(cdd_pkg::YEAR_BASE);
    assign prev_len  = cdd_pkg::month_days(prev_mon, cdd_pkg::is_leap(full_year));

    // Seconds up to years; each sign bit is the borrow into the next field.
    assign sec0  = 8'(hi.second) - 8'(lo.second);
    assign sec1  = sec0[7] ? sec0 + cdd_pkg::SEC_WRAP : sec0;

    assign min0  = 8'(hi.minute) - 8'(lo.minute) - 8'(sec0[7]);
    assign min1  = min0[7] ? min0 + cdd_pkg::MIN_WRAP : min0;

    assign hour0 = 8'(hi.hour) - 8'(lo.hour) - 8'(min0[7]);
    assign hour1 = hour0[7] ? hour0 + cdd_pkg::HOUR_WRAP : hour0;

    // Single borrow from the month: the day count may stay negative.
    assign day0  = 8'(hi.day) - 8'(lo.day) - 8'(hour0[7]);
    assign day1  = day0[7] ? day0 + 8'(prev_len) : day0;

    assign mon0  = 8'(hi.month) - 8'(lo.month) - 8'(day0[7]);
    assign mon1  = mon0[7] ? mon0 + cdd_pkg::MONTH_WRAP : mon0;

    assign yr1   = 14'(hi.year) - 14'(lo.year) - 14'(mon0[7]);

    assign n_sec  = rev ? -sec1  : sec1;
    assign n_min  = rev ? -min1  : min1;
    assign n_hour = rev ? -hour1 : hour1;
    assign n_day  = rev ? -day1  : day1;
    assign n_mon  = rev ? -mon1  : mon1;
    assign n_yr   = rev ? -yr1   : yr1;

    // --------------------------------------------------------- result register
    logic [12:0] r_yr;
    logic [4:0]  r_mon;
    logic [5:0]  r_day;
    logic [5:0]  r_hour;
    logic [6:0]  r_min;
    logic [6:0]  r_sec;

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_yr   <= n_yr[12:0];
            r_mon  <= n_mon[4:0];
            r_day  <= n_day[5:0];
            r_hour <= n_hour[5:0];
            r_min  <= n_min[6:0];
            r_sec  <= n_sec[6:0];
        end
    end

    assign o_diff_years   = $signed(r_yr);
    assign o_diff_months  = $signed(r_mon);
    assign o_diff_days    = $signed(r_day);
    assign o_diff_hours   = $signed(r_hour);
    assign o_diff_minutes = $signed(r_min);
    assign o_diff_seconds = $signed(r_sec);

    // -------------------------------------------------------------- assertions
    // An accepted beat always lands in stage 1.
    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_s1_valid)
        else $error("accepted beat missing from stage 1");

    // A beat leaving stage 1 always shows up as a result.
    a_move_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> o_valid)
        else $error("stage 1 beat lost on its way to the result register");

    // A full stage 1 that cannot drain must hold off the sender.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !i_ready) |-> !o_ready)
        else $error("input accepted while both stages are blocked");

    // With the end not before the start, the year count never goes negative.
    a_year_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !rev) |-> !yr1[13])
        else $error("negative years for an ordered pair");

endmodule

`default_nettype wire
